// ===== rtl/acm_pkg.sv =====
// Package of the accumulator machine step core: widths, opcodes, status codes, costs and types.
`timescale 1ns / 1ps

package acm_pkg;

    // Default data memory depth in 64-bit words.
    localparam int MEMORY_WORDS_DEFAULT = 1024;

    localparam int WORD_W   = 64;
    localparam int OPCODE_W = 5;
    localparam int PTR_W    = 20;
    localparam int LEN_W    = 21;
    localparam int STATUS_W = 3;
    localparam int COST_W   = 7;

    // Input beat layout, lowest bit first.
    localparam int IN_OPCODE_LSB  = 0;
    localparam int IN_OPERAND_LSB = IN_OPCODE_LSB + OPCODE_W;
    localparam int IN_GET_LSB     = IN_OPERAND_LSB + WORD_W;
    localparam int IN_USED_W      = IN_GET_LSB + WORD_W;
    localparam int IN_DATA_W      = ((IN_USED_W + 7) / 8) * 8;

    // Result beat layout, lowest bit first.
    localparam int OUT_PTR_LSB    = 0;
    localparam int OUT_STATUS_LSB = OUT_PTR_LSB + PTR_W;
    localparam int OUT_PUTV_LSB   = OUT_STATUS_LSB + STATUS_W;
    localparam int OUT_PUT_LSB    = OUT_PUTV_LSB + 1;
    localparam int OUT_TOTAL_LSB  = OUT_PUT_LSB + WORD_W;
    localparam int OUT_IO_LSB     = OUT_TOTAL_LSB + WORD_W;
    localparam int OUT_USED_W     = OUT_IO_LSB + WORD_W;
    localparam int OUT_DATA_W     = ((OUT_USED_W + 7) / 8) * 8;

    // Opcodes.
    localparam logic [OPCODE_W-1:0] OP_HALT   = 5'd0;
    localparam logic [OPCODE_W-1:0] OP_GET    = 5'd1;
    localparam logic [OPCODE_W-1:0] OP_PUT    = 5'd2;
    localparam logic [OPCODE_W-1:0] OP_LOAD   = 5'd3;
    localparam logic [OPCODE_W-1:0] OP_STORE  = 5'd4;
    localparam logic [OPCODE_W-1:0] OP_LOADI  = 5'd5;
    localparam logic [OPCODE_W-1:0] OP_STOREI = 5'd6;
    localparam logic [OPCODE_W-1:0] OP_ADD    = 5'd7;
    localparam logic [OPCODE_W-1:0] OP_SUB    = 5'd8;
    localparam logic [OPCODE_W-1:0] OP_ADDI   = 5'd9;
    localparam logic [OPCODE_W-1:0] OP_SUBI   = 5'd10;
    localparam logic [OPCODE_W-1:0] OP_SET    = 5'd11;
    localparam logic [OPCODE_W-1:0] OP_HALF   = 5'd12;
    localparam logic [OPCODE_W-1:0] OP_JUMP   = 5'd13;
    localparam logic [OPCODE_W-1:0] OP_JPOS   = 5'd14;
    localparam logic [OPCODE_W-1:0] OP_JZERO  = 5'd15;
    localparam logic [OPCODE_W-1:0] OP_JNEG   = 5'd16;
    localparam logic [OPCODE_W-1:0] OP_RTRN   = 5'd17;

    // Status codes.
    localparam logic [STATUS_W-1:0] STATUS_OK     = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_HALTED = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_NEG    = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_RANGE  = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_BOUNDS = 3'd4;

    // Instruction costs.
    localparam logic [COST_W-1:0] COST_IO       = 7'd100;
    localparam logic [COST_W-1:0] COST_DIRECT   = 7'd10;
    localparam logic [COST_W-1:0] COST_INDIRECT = 7'd20;
    localparam logic [COST_W-1:0] COST_SET      = 7'd50;
    localparam logic [COST_W-1:0] COST_HALF     = 7'd5;
    localparam logic [COST_W-1:0] COST_JUMP     = 7'd1;
    localparam logic [COST_W-1:0] COST_NONE     = 7'd0;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ1,
        ST_READ2
    } state_t;

endpackage

// ===== rtl/accumulator_machine_step_core.sv =====
// Top level of the accumulator machine step core: one instruction executed per input beat.
`timescale 1ns / 1ps

// Usage
// The s_ channel carries one instruction per beat (opcode, operand and the value a get
// instruction stores). Each accepted beat produces exactly one beat on the m_ channel with
// the new instruction pointer, the status, any put value and both running cost totals.
// The cfg_ channel writes program_length; it is always ready and should only be written
// while no instruction is in flight.
// Execution: the result register is loaded when the instruction executes, in ST_READ1 for
// direct instructions and in ST_READ2 for the indirect ones (loadi, storei, addi, subi),
// which need a second dependent read of the data memory.
// Throughput: one direct instruction per cycle while the output register is free; an
// indirect one takes no new beat until its second read is done. The single read port of
// the data memory is the reason; a new beat is taken in the same cycle in which the
// previous instruction executes, and a write to the address being read is forwarded.
// Reset: after aresetn is released the data memory is swept to zero, one word a cycle;
// s_tready stays low during the sweep. The accumulator, the pointer and both totals
// reset to zero and program_length to one.
// Stall: the result sits in an output register. While it is not taken, the next
// instruction may still be accepted and read its operands, but it does not execute until
// the output register is free, so no result is lost or overtaken.
module accumulator_machine_step_core #(
    parameter int MEMORY_WORDS = acm_pkg::MEMORY_WORDS_DEFAULT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Instruction beats. Fields from bit 0: opcode[4:0], operand[68:5], get_value[132:69].
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [acm_pkg::IN_DATA_W-1:0]  s_tdata,
    // Result beats. Fields from bit 0: next_pointer[19:0], status[22:20], put_valid[23],
    // put_value[87:24], total_cost[151:88], io_cost[215:152].
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [acm_pkg::OUT_DATA_W-1:0] m_tdata,
    // Configuration write of program_length.
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [acm_pkg::LEN_W-1:0]      cfg_data
);

    localparam int AW = $clog2(MEMORY_WORDS);
    localparam int WW = acm_pkg::WORD_W;
    localparam logic [WW-1:0] MEM_LIMIT = WW'(MEMORY_WORDS);
    localparam logic [AW-1:0] LAST_ADDR = AW'(MEMORY_WORDS - 1);

    // Data memory. Word 0 is shadowed by acc_reg, which is what reads of address 0 see.
    logic [WW-1:0] mem [MEMORY_WORDS];

    acm_pkg::state_t state_reg, state_next;

    logic [AW-1:0]                   clr_cnt_reg, clr_cnt_next;
    logic [acm_pkg::LEN_W-1:0]       prog_len_reg;
    logic [acm_pkg::PTR_W-1:0]       ip_reg, ip_next;
    logic [WW-1:0]                   acc_reg;
    logic [WW-1:0]                   total_reg, total_next;
    logic [WW-1:0]                   io_reg, io_next;

    // Instruction held while it executes.
    logic [acm_pkg::OPCODE_W-1:0]    op_reg;
    logic [WW-1:0]                   arg_reg;
    logic [WW-1:0]                   getv_reg;
    logic [WW-1:0]                   ind_reg;
    logic [WW-1:0]                   mem_q_reg;
    logic                            fwd_valid_reg;
    logic [WW-1:0]                   fwd_data_reg;

    // Output register and the beat that loads it.
    logic                            m_tvalid_reg;
    logic [acm_pkg::OUT_DATA_W-1:0]  m_tdata_reg;
    logic [acm_pkg::OUT_DATA_W-1:0]  out_word;

    // Input fields.
    logic [acm_pkg::OPCODE_W-1:0]    s_opcode;
    logic [WW-1:0]                   s_operand;
    logic [WW-1:0]                   s_get_value;

    // Handshake and memory port control.
    logic                            accept;
    logic                            out_free;
    logic                            ind_op;
    logic                            exec_now;
    logic                            exec_fire;
    logic                            rd_en;
    logic [AW-1:0]                   rd_addr;
    logic                            wr_en;
    logic [AW-1:0]                   wr_addr;
    logic [WW-1:0]                   wr_data;

    // Execution.
    logic [WW-1:0]                   dir_word;
    logic [WW-1:0]                   ind_word;
    logic [acm_pkg::STATUS_W-1:0]    status;
    logic                            halt_op;
    logic                            no_check;
    logic                            ok;
    logic                            do_wr;
    logic [WW-1:0]                   waddr;
    logic [WW-1:0]                   wval;
    logic [acm_pkg::COST_W-1:0]      cost;
    logic [acm_pkg::COST_W-1:0]      io_cost;
    logic                            put;
    logic [WW-1:0]                   putv;
    logic [WW-1:0]                   nptr;
    logic [WW-1:0]                   ip_ext;
    logic [WW-1:0]                   len_ext;
    logic                            acc_pos;

    assign s_opcode    = s_tdata[acm_pkg::IN_OPCODE_LSB +: acm_pkg::OPCODE_W];
    assign s_operand   = s_tdata[acm_pkg::IN_OPERAND_LSB +: WW];
    assign s_get_value = s_tdata[acm_pkg::IN_GET_LSB +: WW];

    assign out_free = !m_tvalid_reg || m_tready;
    assign ind_op   = (op_reg == acm_pkg::OP_LOADI) || (op_reg == acm_pkg::OP_STOREI) ||
                      (op_reg == acm_pkg::OP_ADDI)  || (op_reg == acm_pkg::OP_SUBI);
    assign exec_now = ((state_reg == acm_pkg::ST_READ1) && !ind_op) ||
                      (state_reg == acm_pkg::ST_READ2);
    assign exec_fire = exec_now && out_free;
    assign accept    = s_tvalid && s_tready;

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            acm_pkg::ST_CLEAR: begin
                if (clr_cnt_reg == LAST_ADDR) begin
                    state_next = acm_pkg::ST_IDLE;
                end
            end
            acm_pkg::ST_IDLE: begin
                if (accept) begin
                    state_next = acm_pkg::ST_READ1;
                end
            end
            acm_pkg::ST_READ1: begin
                if (ind_op) begin
                    state_next = acm_pkg::ST_READ2;
                end else if (exec_fire) begin
                    state_next = accept ? acm_pkg::ST_READ1 : acm_pkg::ST_IDLE;
                end
            end
            acm_pkg::ST_READ2: begin
                if (exec_fire) begin
                    state_next = accept ? acm_pkg::ST_READ1 : acm_pkg::ST_IDLE;
                end
            end
            default: state_next = acm_pkg::ST_CLEAR;
        endcase
    end

    // State-dependent outputs: input ready, read port and the clearing counter.
    always_comb begin
        s_tready     = 1'b0;
        rd_en        = 1'b0;
        rd_addr      = s_operand[AW-1:0];
        clr_cnt_next = clr_cnt_reg;
        unique case (state_reg)
            acm_pkg::ST_CLEAR: begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
            end
            acm_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                rd_en    = s_tvalid;
            end
            acm_pkg::ST_READ1: begin
                if (ind_op) begin
                    // Second, dependent read: the word found at the direct address.
                    rd_en   = 1'b1;
                    rd_addr = dir_word[AW-1:0];
                end else begin
                    s_tready = exec_fire;
                    rd_en    = exec_fire && s_tvalid;
                end
            end
            acm_pkg::ST_READ2: begin
                s_tready = exec_fire;
                rd_en    = exec_fire && s_tvalid;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    assign cfg_ready = 1'b1;

    // Operand words. Address 0 is the accumulator; a write made in the cycle of the read
    // issue is taken from the forwarding register.
    always_comb begin
        if (arg_reg[AW-1:0] == '0) begin
            dir_word = acc_reg;
        end else if (fwd_valid_reg) begin
            dir_word = fwd_data_reg;
        end else begin
            dir_word = mem_q_reg;
        end
        ind_word = (ind_reg[AW-1:0] == '0) ? acc_reg : mem_q_reg;
    end

    assign ip_ext  = {{(WW - acm_pkg::PTR_W){1'b0}}, ip_reg};
    assign len_ext = {{(WW - acm_pkg::LEN_W){1'b0}}, prog_len_reg};
    assign acc_pos = !acc_reg[WW-1] && (acc_reg != '0);

    // Instruction execution.
    always_comb begin
        halt_op  = (op_reg == acm_pkg::OP_HALT) || (op_reg > acm_pkg::OP_RTRN);
        no_check = (op_reg == acm_pkg::OP_SET)  || (op_reg == acm_pkg::OP_JUMP) ||
                   (op_reg == acm_pkg::OP_JPOS) || (op_reg == acm_pkg::OP_JZERO) ||
                   (op_reg == acm_pkg::OP_JNEG);
        do_wr    = 1'b0;
        waddr    = '0;
        wval     = '0;
        cost     = acm_pkg::COST_NONE;
        io_cost  = acm_pkg::COST_NONE;
        put      = 1'b0;
        putv     = '0;
        nptr     = ip_ext + 64'd1;

        unique case (op_reg)
            acm_pkg::OP_GET: begin
                do_wr = 1'b1; waddr = arg_reg; wval = getv_reg;
                cost = acm_pkg::COST_IO; io_cost = acm_pkg::COST_IO;
            end
            acm_pkg::OP_PUT: begin
                put = 1'b1; putv = dir_word;
                cost = acm_pkg::COST_IO; io_cost = acm_pkg::COST_IO;
            end
            acm_pkg::OP_LOAD: begin
                do_wr = 1'b1; wval = dir_word; cost = acm_pkg::COST_DIRECT;
            end
            acm_pkg::OP_STORE: begin
                do_wr = 1'b1; waddr = arg_reg; wval = acc_reg; cost = acm_pkg::COST_DIRECT;
            end
            acm_pkg::OP_LOADI: begin
                do_wr = 1'b1; wval = ind_word; cost = acm_pkg::COST_INDIRECT;
            end
            acm_pkg::OP_STOREI: begin
                do_wr = 1'b1; waddr = ind_reg; wval = acc_reg; cost = acm_pkg::COST_INDIRECT;
            end
            acm_pkg::OP_ADD: begin
                do_wr = 1'b1; wval = acc_reg + dir_word; cost = acm_pkg::COST_DIRECT;
            end
            acm_pkg::OP_SUB: begin
                do_wr = 1'b1; wval = acc_reg - dir_word; cost = acm_pkg::COST_DIRECT;
            end
            acm_pkg::OP_ADDI: begin
                do_wr = 1'b1; wval = acc_reg + ind_word; cost = acm_pkg::COST_INDIRECT;
            end
            acm_pkg::OP_SUBI: begin
                do_wr = 1'b1; wval = acc_reg - ind_word; cost = acm_pkg::COST_INDIRECT;
            end
            acm_pkg::OP_SET: begin
                do_wr = 1'b1; wval = arg_reg; cost = acm_pkg::COST_SET;
            end
            acm_pkg::OP_HALF: begin
                do_wr = 1'b1; wval = {acc_reg[WW-1], acc_reg[WW-1:1]};
                cost = acm_pkg::COST_HALF;
            end
            acm_pkg::OP_JUMP: begin
                nptr = ip_ext + arg_reg; cost = acm_pkg::COST_JUMP;
            end
            acm_pkg::OP_JPOS: begin
                if (acc_pos) begin
                    nptr = ip_ext + arg_reg;
                end
                cost = acm_pkg::COST_JUMP;
            end
            acm_pkg::OP_JZERO: begin
                if (acc_reg == '0) begin
                    nptr = ip_ext + arg_reg;
                end
                cost = acm_pkg::COST_JUMP;
            end
            acm_pkg::OP_JNEG: begin
                if (acc_reg[WW-1]) begin
                    nptr = ip_ext + arg_reg;
                end
                cost = acm_pkg::COST_JUMP;
            end
            acm_pkg::OP_RTRN: begin
                nptr = dir_word;
            end
            default: begin
                // Halt and undefined opcodes change nothing.
                nptr = ip_ext;
            end
        endcase

        priority if (halt_op) begin
            status = acm_pkg::STATUS_HALTED;
        end else if (!no_check && arg_reg[WW-1]) begin
            status = acm_pkg::STATUS_NEG;
        end else if (!no_check && (arg_reg >= MEM_LIMIT)) begin
            status = acm_pkg::STATUS_RANGE;
        end else if (ind_op && (ind_reg >= MEM_LIMIT)) begin
            status = acm_pkg::STATUS_RANGE;
        end else if (nptr[WW-1] || (nptr >= len_ext)) begin
            status = acm_pkg::STATUS_BOUNDS;
        end else begin
            status = acm_pkg::STATUS_OK;
        end

        ok         = (status == acm_pkg::STATUS_OK);
        ip_next    = ok ? nptr[acm_pkg::PTR_W-1:0] : ip_reg;
        total_next = ok ? total_reg + WW'(cost) : total_reg;
        io_next    = ok ? io_reg + WW'(io_cost) : io_reg;
    end

    // Result beat assembled from the execution outputs.
    always_comb begin
        out_word = '0;
        out_word[acm_pkg::OUT_PTR_LSB +: acm_pkg::PTR_W]       = ip_next;
        out_word[acm_pkg::OUT_STATUS_LSB +: acm_pkg::STATUS_W] = status;
        out_word[acm_pkg::OUT_PUTV_LSB]                        = put && ok;
        out_word[acm_pkg::OUT_PUT_LSB +: WW]                   = ok ? putv : '0;
        out_word[acm_pkg::OUT_TOTAL_LSB +: WW]                 = total_next;
        out_word[acm_pkg::OUT_IO_LSB +: WW]                    = io_next;
    end

    // Memory write port: zeros during the sweep, then the executing instruction.
    always_comb begin
        if (state_reg == acm_pkg::ST_CLEAR) begin
            wr_en   = 1'b1;
            wr_addr = clr_cnt_reg;
            wr_data = '0;
        end else begin
            wr_en   = exec_fire && ok && do_wr;
            wr_addr = waddr[AW-1:0];
            wr_data = wval;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            mem_q_reg <= mem[rd_addr];
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= acm_pkg::ST_CLEAR;
            clr_cnt_reg   <= '0;
            prog_len_reg  <= acm_pkg::LEN_W'(1);
            ip_reg        <= '0;
            acc_reg       <= '0;
            total_reg     <= '0;
            io_reg        <= '0;
            fwd_valid_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            if (cfg_valid && cfg_ready) begin
                prog_len_reg <= cfg_data;
            end
            if (exec_fire) begin
                ip_reg    <= ip_next;
                total_reg <= total_next;
                io_reg    <= io_next;
                if (ok && do_wr && (waddr[AW-1:0] == '0)) begin
                    acc_reg <= wval;
                end
            end
            if (accept) begin
                fwd_valid_reg <= wr_en && (wr_addr == rd_addr);
            end
            if (exec_fire) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg       <= s_opcode;
            arg_reg      <= s_operand;
            getv_reg     <= s_get_value;
            fwd_data_reg <= wr_data;
        end
        if (state_reg == acm_pkg::ST_READ1) begin
            ind_reg <= dir_word;
        end
        if (exec_fire) begin
            m_tdata_reg <= out_word;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // No instruction enters while the memory is being swept.
    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == acm_pkg::ST_CLEAR) |-> !s_tready)
        else $error("instruction accepted during memory sweep");

    // The read port never serves a new instruction and a second indirect read at once.
    a_single_read: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |-> !((state_reg == acm_pkg::ST_READ1) && ind_op))
        else $error("read port claimed twice");

    // A failed instruction leaves the memory untouched.
    a_atomic_error: assert property (@(posedge aclk) disable iff (!aresetn)
        (wr_en && (state_reg != acm_pkg::ST_CLEAR)) |-> ok)
        else $error("memory written by a failed instruction");

    // The I/O total moves only together with the overall total.
    a_io_with_total: assert property (@(posedge aclk) disable iff (!aresetn)
        (io_reg != $past(io_reg)) |-> (total_reg != $past(total_reg)))
        else $error("io cost changed without total cost");

endmodule
